FILE: design/eusp_pkg.sv
// Package: widths, register indexes, reset values and mode encodings for the encoder unwrap block.
`default_nettype none
package eusp_pkg;

  localparam int RAW_W   = 16;
  localparam int DELTA_W = 17;
  localparam int SPEED_W = 37;
  localparam int POS_W   = 32;
  localparam int SCALE_W = 28;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_MAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODER_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 2'd2;

  localparam logic [RAW_W-1:0]   COUNTS_MAX_RST  = 16'd8191;
  localparam logic               MODE_RST        = 1'b0;
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 28'd25230;

  localparam logic MODE_ABSOLUTE    = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

endpackage : eusp_pkg
`default_nettype wire

FILE: design/encoder_unwrap_speed_position.sv
// Encoder wrap correction with speed and accumulated position outputs.
//
//   channel | dir | handshake                  | payload
//   s       | in  | s_tvalid / s_tready        | s_tdata: raw_count
//   m       | out | m_tvalid / m_tready        | m_tdata: count_delta, speed_q8, position_total
//   cfg     | in  | cfg_wr_en                  | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while m_tready is high; an accepted input passes
// through the input register, then the result register. The unwrap, one 17x29
// multiply and the position add sit between the two registers.
// rst is synchronous: clears valids, previous count, accumulator and started flag,
// and restores the register defaults. A stalled result holds the output register
// while one further transaction waits in the input register.
`default_nettype none
module encoder_unwrap_speed_position
  import eusp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] raw_count
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // [16:0] count_delta, [53:17] speed_q8,
                                                 // [85:54] position_total, [87:86] zero
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [SCALE_W-1:0]     cfg_wdata
);

  logic [RAW_W-1:0]   counts_max;
  logic               encoder_mode;
  logic [SCALE_W-1:0] speed_scale;

  logic               in_valid;
  logic [RAW_W-1:0]   in_raw;

  logic [RAW_W-1:0]   previous_count;
  logic [POS_W-1:0]   position_accumulator;
  logic               started;

  logic                      out_valid;
  logic signed [DELTA_W-1:0] out_delta;
  logic signed [SPEED_W-1:0] out_speed;
  logic [POS_W-1:0]          out_pos;

  logic advance;
  logic fire;

  logic signed [17:0] diff;
  logic signed [17:0] half;
  logic signed [17:0] span;
  logic signed [17:0] corrected;
  logic signed [DELTA_W-1:0] delta;
  logic signed [45:0] prod;
  logic signed [SPEED_W-1:0] speed;
  logic [POS_W-1:0] position_accumulator_next;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_max   <= COUNTS_MAX_RST;
      encoder_mode <= MODE_RST;
      speed_scale  <= SPEED_SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COUNTS_MAX:   counts_max   <= cfg_wdata[RAW_W-1:0];
        REG_ENCODER_MODE: encoder_mode <= cfg_wdata[0];
        REG_SPEED_SCALE:  speed_scale  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unwrap, scale, accumulate
  always_comb begin
    diff = $signed({2'b00, in_raw}) - $signed({2'b00, previous_count});
    half = $signed({3'b000, counts_max[RAW_W-1:1]});
    if (encoder_mode == MODE_INCREMENTAL) begin
      span = 18'sd65536;
    end else begin
      span = $signed({2'b00, counts_max}) + 18'sd1;
    end
    priority if (diff < -half) begin
      corrected = diff + span;
    end else if (diff > half) begin
      corrected = diff - span;
    end else begin
      corrected = diff;
    end
    delta = corrected[DELTA_W-1:0];
    prod  = delta * $signed({1'b0, speed_scale});
    if (encoder_mode == MODE_INCREMENTAL) begin
      speed = {prod[45], prod[45:10]};
    end else begin
      speed = prod[44:8];
    end
    if (started) begin
      position_accumulator_next = position_accumulator
                                + {{(POS_W-DELTA_W){delta[DELTA_W-1]}}, delta};
    end else begin
      position_accumulator_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid             <= 1'b0;
      out_valid            <= 1'b0;
      previous_count       <= '0;
      position_accumulator <= '0;
      started              <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        previous_count       <= in_raw;
        position_accumulator <= position_accumulator_next;
        started              <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata[RAW_W-1:0];
    end
    if (fire) begin
      out_delta <= delta;
      out_speed <= speed;
      out_pos   <= position_accumulator_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_pos, out_speed, out_delta};

endmodule : encoder_unwrap_speed_position
`default_nettype wire

FILE: design/eusp_checker.sv
// Port-level checker for the encoder unwrap block, bound to the top level.
`default_nettype none
module eusp_checker
  import eusp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [DELTA_W-1:0] chk_delta;
  logic [SPEED_W-1:0] chk_speed;

  assign chk_delta = m_tdata[DELTA_W-1:0];
  assign chk_speed = m_tdata[DELTA_W+SPEED_W-1:DELTA_W];

  a_no_valid_after_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_delta != 17'h10000)
    else $error("count_delta outside corrected range");

  a_speed_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !chk_delta[DELTA_W-1] |-> !chk_speed[SPEED_W-1])
    else $error("negative speed for non-negative delta");

endmodule : eusp_checker

bind encoder_unwrap_speed_position eusp_checker u_eusp_checker (.*);
`default_nettype wire

FILE: bench/encoder_unwrap_speed_position_tb.sv
// Testbench for encoder_unwrap_speed_position: directed table, then random phases, checked by a predictor.
module encoder_unwrap_speed_position_tb;
  import eusp_pkg::*;

  localparam int QUIET_LO    = 600;
  localparam int QUIET_HI    = 800;
  localparam int HOLD_AT     = 350;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES      = 7;
  localparam int PHASE_LEN   = 150;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [SPEED_W-1:0] speed;
    logic signed [POS_W-1:0]   pos;
  } unwrap_result_t;

  typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [RAW_W-1:0]   raw;
    logic               mode;
    logic [SCALE_W-1:0] scale;
    bit                 typed;
    unwrap_result_t     want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SCALE_W-1:0]     cfg_wdata;

  // predictor state and register copies
  logic [RAW_W-1:0]   prev_raw;
  logic [POS_W-1:0]   pos_acc;
  logic               started;
  logic [RAW_W-1:0]   cnt_max;
  logic               enc_mode;
  logic [SCALE_W-1:0] scl;

  unwrap_result_t pending[$];
  stim_row_t      rows[$];
  logic [RAW_W-1:0] last_raw;
  int samples_sent;
  int results_seen;
  int mismatches;
  int hold_left;
  bit hold_done;

  encoder_unwrap_speed_position i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [15:0] raw_count
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [16:0] count_delta, [53:17] speed_q8, [85:54] position_total
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic unwrap_result_t unwrap_sample(input logic [RAW_W-1:0] raw);
    int half;
    int span;
    int d;
    longint product;
    longint sp;
    unwrap_result_t res;
    half = int'(cnt_max >> 1);
    span = (enc_mode == MODE_INCREMENTAL) ? 65536 : int'(cnt_max) + 1;
    d = int'(raw) - int'(prev_raw);
    if (d < -half) begin
      d += span;
    end else if (d > half) begin
      d -= span;
    end
    product = longint'(d) * longint'(scl);
    sp = (enc_mode == MODE_INCREMENTAL) ? (product >>> 10) : (product >>> 8);
    res.delta = d[DELTA_W-1:0];
    res.speed = sp[SPEED_W-1:0];
    prev_raw = raw;
    pos_acc = pos_acc + d[POS_W-1:0];
    if (!started) begin
      pos_acc = '0;
      started = 1'b1;
    end
    res.pos = pos_acc;
    return res;
  endfunction

  // mostly encoder-like steps from the last reading, some crossing the wrap, plus noise and corner values
  function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] last);
    int modulus;
    int lim;
    int step;
    int v;
    int unsigned pick;
    logic [RAW_W-1:0] r;
    modulus = (enc_mode == MODE_INCREMENTAL) ? 65536 : int'(cnt_max) + 1;
    lim = (modulus - 1) / 2;
    pick = $urandom_range(0, 99);
    if (pick < 30 && lim > 64) lim = 64;
    if (pick < 70) begin
      step = int'($urandom_range(0, 2 * lim)) - lim;
      v = (int'(last) + step) % modulus;
      if (v < 0) v += modulus;
      r = v[RAW_W-1:0];
    end else if (pick < 90) begin
      r = RAW_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       r = '0;
        1:       r = cnt_max;
        2:       r = cnt_max + 1'b1;
        default: r = '1;
      endcase
    end
    return r;
  endfunction

  task automatic offer_sample(input logic [RAW_W-1:0] raw, input bit typed,
                              input unwrap_result_t typed_want);
    unwrap_result_t want;
    while (!(samples_sent >= QUIET_LO && samples_sent < QUIET_HI) &&
           $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    want = unwrap_sample(raw);
    if (typed) want = typed_want;
    pending.push_back(want);
    samples_sent++;
    last_raw = raw;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [RAW_W-1:0] cm, input logic md,
                            input logic [SCALE_W-1:0] sc);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_COUNTS_MAX;
    cfg_wdata <= SCALE_W'(cm);
    @(posedge clk);
    cfg_index <= REG_ENCODER_MODE;
    cfg_wdata <= SCALE_W'(md);
    @(posedge clk);
    cfg_index <= REG_SPEED_SCALE;
    cfg_wdata <= sc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cnt_max  = cm;
    enc_mode = md;
    scl      = sc;
  endtask

  task automatic add_config(input logic [RAW_W-1:0] cm, input logic md,
                            input logic [SCALE_W-1:0] sc);
    stim_row_t row;
    row.kind  = ROW_CONFIG;
    row.raw   = cm;
    row.mode  = md;
    row.scale = sc;
    row.typed = 1'b0;
    row.want  = '0;
    rows.push_back(row);
  endtask

  task automatic add_sample(input logic [RAW_W-1:0] raw, input bit typed,
                            input longint d, input longint s, input longint p);
    stim_row_t row;
    row.kind       = ROW_SAMPLE;
    row.raw        = raw;
    row.mode       = MODE_ABSOLUTE;
    row.scale      = '0;
    row.typed      = typed;
    row.want.delta = d[DELTA_W-1:0];
    row.want.speed = s[SPEED_W-1:0];
    row.want.pos   = p[POS_W-1:0];
    rows.push_back(row);
  endtask

  always @(posedge clk) begin : result_check
    unwrap_result_t got;
    unwrap_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.delta = m_tdata[DELTA_W-1:0];
        got.speed = m_tdata[DELTA_W+SPEED_W-1:DELTA_W];
        got.pos   = m_tdata[DELTA_W+SPEED_W+POS_W-1:DELTA_W+SPEED_W];
        results_seen++;
        if (pending.size() == 0) begin
          report_mismatch("result with no expectation waiting");
        end else begin
          want = pending.pop_front();
          if (got.delta !== want.delta)
            report_mismatch($sformatf("count_delta got %0d expected %0d",
                                      got.delta, want.delta));
          if (got.speed !== want.speed)
            report_mismatch($sformatf("speed_q8 got %0d expected %0d",
                                      got.speed, want.speed));
          if (got.pos !== want.pos)
            report_mismatch($sformatf("position_total got %0d expected %0d",
                                      got.pos, want.pos));
        end
      end
      // long hold-off so the block fills up and back-pressures its input
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin : stimulus
    unwrap_result_t none;
    none         = '0;
    samples_sent = 0;
    results_seen = 0;
    mismatches   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    last_raw     = '0;
    prev_raw     = '0;
    pos_acc      = '0;
    started      = 1'b0;
    cnt_max      = COUNTS_MAX_RST;
    enc_mode     = MODE_RST;
    scl          = SPEED_SCALE_RST;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_COUNTS_MAX;
    cfg_wdata <= '0;

    // reset defaults: first sample clears position, then floor of negative speed
    add_sample(16'd100,   1'b1, 100,  9855,    0);
    add_sample(16'd0,     1'b1, -100, -9856, -100);
    add_sample(16'd8191,  1'b1, -1,   -99,   -101);
    add_sample(16'd0,     1'b1, 1,    98,    -100);
    add_sample(16'd65535, 1'b0, 0, 0, 0);
    add_sample(16'd32768, 1'b0, 0, 0, 0);
    add_config(16'd65535, MODE_ABSOLUTE, 28'hFFFFFFF);
    add_sample(16'd0,     1'b0, 0, 0, 0);
    add_sample(16'd65535, 1'b0, 0, 0, 0);
    add_sample(16'd32767, 1'b0, 0, 0, 0);
    add_sample(16'd0,     1'b0, 0, 0, 0);
    // zero counts_max: threshold zero, wrap by one
    add_config(16'd0, MODE_ABSOLUTE, 28'd256);
    add_sample(16'd5, 1'b0, 0, 0, 0);
    add_sample(16'd6, 1'b0, 0, 0, 0);
    add_sample(16'd5, 1'b0, 0, 0, 0);
    add_config(16'd65535, MODE_INCREMENTAL, 28'hFFFFFFF);
    add_sample(16'd0,     1'b0, 0, 0, 0);
    add_sample(16'd32767, 1'b0, 0, 0, 0);
    add_sample(16'd65535, 1'b0, 0, 0, 0);
    add_sample(16'd0,     1'b0, 0, 0, 0);
    // delta extremes with the largest scale
    add_config(16'd1, MODE_INCREMENTAL, 28'hFFFFFFF);
    add_sample(16'd1, 1'b0, 0, 0, 0);
    add_sample(16'd0, 1'b0, 0, 0, 0);
    add_config(16'd1, MODE_ABSOLUTE, SPEED_SCALE_RST);
    add_sample(16'd3, 1'b0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CONFIG)
        set_config(rows[i].raw, rows[i].mode, rows[i].scale);
      else
        offer_sample(rows[i].raw, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(COUNTS_MAX_RST, MODE_ABSOLUTE, SCALE_W'($urandom));
        1: set_config(16'hFFFF, MODE_ABSOLUTE, 28'hFFFFFFF);
        2: set_config(16'd1, MODE_ABSOLUTE, SCALE_W'($urandom));
        3: set_config(RAW_W'($urandom_range(1, 65535)), MODE_INCREMENTAL, SCALE_W'($urandom));
        4: set_config(16'hFFFF, MODE_INCREMENTAL, 28'hFFFFFFF);
        5: set_config(RAW_W'($urandom_range(1, 65535)), 1'($urandom), '0);
        default: set_config(RAW_W'($urandom_range(1, 65535)), 1'($urandom),
                            SCALE_W'($urandom));
      endcase
      for (int n = 0; n < PHASE_LEN; n++) offer_sample(pick_raw(last_raw), 1'b0, none);
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("encoder_unwrap_speed_position test passed");
    end else begin
      $display("encoder_unwrap_speed_position test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("encoder_unwrap_speed_position test failed");
    $finish;
  end

endmodule
